[rtl/core/rgb_to_hsv_8bit_unit_assert.svh]
// Assertion macros shared by the RGB to HSV conversion unit.
`ifndef RGB_TO_HSV_8BIT_UNIT_ASSERT_SVH
`define RGB_TO_HSV_8BIT_UNIT_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define RHSV_ASSERT_IMPLIES(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error("rhsv: same-cycle check failed");

// Check that a condition is followed by another a fixed number of cycles later.
`define RHSV_ASSERT_DELAY(lbl, clk_s, rstn_s, dly, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> ##dly (cons)) \
    else $error("rhsv: delayed check failed");

`endif

[rtl/core/rhsv_pkg.sv]
// Shared types and constants for the RGB to HSV conversion unit.
`timescale 1ns / 1ps

package rhsv_pkg;

  localparam int CH_W            = 8;
  localparam int NUM_W           = 16;
  localparam int QUO_W           = 8;
  localparam int DIV_STAGES      = QUO_W;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [CH_W-1:0]  HUE_BASE_RED   = 8'd0;
  localparam logic [CH_W-1:0]  HUE_BASE_GREEN = 8'd85;
  localparam logic [CH_W-1:0]  HUE_BASE_BLUE  = 8'd171;
  localparam logic [NUM_W-1:0] HUE_SCALE      = 16'd43;

  // One classified pixel, ready for the dividers.
  typedef struct packed {
    logic [NUM_W-1:0] sat_num;   // 255 * delta
    logic [NUM_W-1:0] hue_num;   // 43 * |diff|
    logic [CH_W-1:0]  hi;        // largest channel, saturation divisor
    logic [CH_W-1:0]  delta;     // max - min, hue divisor
    logic [CH_W-1:0]  base;      // hue sector offset
    logic             neg;       // hue term is negative
    logic             sat_zero;  // black pixel
    logic             hue_zero;  // grey pixel
    logic [CH_W-1:0]  alpha;
  } item_t;

  // Queue status seen by the top level and the back end.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[rtl/core/rgb_to_hsv_8bit_unit.sv]
// RGB to HSV conversion unit: one pixel per clock.
// A pixel is taken on any clock where start is high and busy is low, and its
// hue, saturation, brightness and alpha appear on the out_ ports for exactly one
// cycle, flagged by out_strobe. A new pixel may be started every cycle. Latency
// is set by the eight-stage restoring divider pipeline in the back end (one
// quotient bit per stage) plus the queue and output registers.
// The back end never stalls, so the queue drains every cycle and busy stays low
// after reset; the output cannot be held off and must be captured when flagged.
`timescale 1ns / 1ps
`include "rgb_to_hsv_8bit_unit_assert.svh"

module rgb_to_hsv_8bit_unit #(
  parameter int QUEUE_DEPTH = rhsv_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [rhsv_pkg::CH_W-1:0]  in_red,
  input  logic [rhsv_pkg::CH_W-1:0]  in_green,
  input  logic [rhsv_pkg::CH_W-1:0]  in_blue,
  input  logic [rhsv_pkg::CH_W-1:0]  in_alpha_in,
  output logic                       out_strobe,
  output logic [rhsv_pkg::CH_W-1:0]  out_hue,
  output logic [rhsv_pkg::CH_W-1:0]  out_saturation,
  output logic [rhsv_pkg::CH_W-1:0]  out_brightness,
  output logic [rhsv_pkg::CH_W-1:0]  out_alpha_out
);
  import rhsv_pkg::*;

  localparam int LATENCY = DIV_STAGES + 2;

  logic    accept;
  logic    push;
  item_t   push_item;
  item_t   head;
  logic    pop;
  q_stat_t q_stat;

  assign busy   = q_stat.full;
  assign accept = start && !busy;

  rhsv_front u_front (
    .accept (accept),
    .red    (in_red),
    .green  (in_green),
    .blue   (in_blue),
    .alpha  (in_alpha_in),
    .push   (push),
    .item   (push_item)
  );

  rhsv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  rhsv_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .head           (head),
    .pop            (pop),
    .out_strobe     (out_strobe),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_brightness (out_brightness),
    .out_alpha_out  (out_alpha_out)
  );

  // The back end drains the queue every cycle, so it never fills
  `RHSV_ASSERT_IMPLIES(a_never_busy, clk, rst_n, 1'b1, !busy)
  // Every accepted transaction yields a result after the pipeline latency
  `RHSV_ASSERT_DELAY(a_fixed_latency, clk, rst_n, LATENCY, accept, out_strobe)
  // A black pixel reports zero saturation and hue
  `RHSV_ASSERT_IMPLIES(a_black_zero, clk, rst_n, out_strobe && (out_brightness == '0),
                       (out_saturation == '0) && (out_hue == '0))

endmodule

[rtl/core/rhsv_front.sv]
// Front end: finds max, min and hue sector of a pixel and builds the divider operands.
`timescale 1ns / 1ps

module rhsv_front (
  input  logic                       accept,
  input  logic [rhsv_pkg::CH_W-1:0]  red,
  input  logic [rhsv_pkg::CH_W-1:0]  green,
  input  logic [rhsv_pkg::CH_W-1:0]  blue,
  input  logic [rhsv_pkg::CH_W-1:0]  alpha,
  output logic                       push,
  output rhsv_pkg::item_t            item
);
  import rhsv_pkg::*;

  logic [CH_W-1:0] hi;
  logic [CH_W-1:0] lo;
  logic [CH_W-1:0] delta;
  logic [CH_W-1:0] diff_p;
  logic [CH_W-1:0] diff_m;
  logic [CH_W-1:0] mag;
  logic [CH_W-1:0] base;
  logic            neg;

  // Take the channel extremes
  always_comb begin
    hi = (red > green) ? red : green;
    hi = (hi > blue) ? hi : blue;
    lo = (red < green) ? red : green;
    lo = (lo < blue) ? lo : blue;
    delta = hi - lo;
  end

  // Pick the hue sector: red wins ties, then green
  always_comb begin
    if (hi == red) begin
      base   = HUE_BASE_RED;
      diff_p = green;
      diff_m = blue;
    end else if (hi == green) begin
      base   = HUE_BASE_GREEN;
      diff_p = blue;
      diff_m = red;
    end else begin
      base   = HUE_BASE_BLUE;
      diff_p = red;
      diff_m = green;
    end
    neg = diff_m > diff_p;
    mag = neg ? (diff_m - diff_p) : (diff_p - diff_m);
  end

  // Build the divider operands
  always_comb begin
    item.sat_num  = {delta, {CH_W{1'b0}}} - NUM_W'(delta);
    item.hue_num  = NUM_W'(mag) * HUE_SCALE;
    item.hi       = hi;
    item.delta    = delta;
    item.base     = base;
    item.neg      = neg;
    item.sat_zero = (hi == '0);
    item.hue_zero = (delta == '0);
    item.alpha    = alpha;
  end

  assign push = accept;

endmodule

[rtl/core/rhsv_queue.sv]
// Short queue between the front end and the divider pipeline.
`timescale 1ns / 1ps

module rhsv_queue #(
  parameter int DEPTH = rhsv_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rhsv_pkg::item_t    push_item,
  input  logic               pop,
  output rhsv_pkg::item_t    head,
  output rhsv_pkg::q_stat_t  stat
);
  import rhsv_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = slot_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the incoming transaction
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[rtl/core/rhsv_back.sv]
// Back end: pipelined restoring dividers for saturation and hue, then output register.
`timescale 1ns / 1ps

module rhsv_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rhsv_pkg::q_stat_t          q_stat,
  input  rhsv_pkg::item_t            head,
  output logic                       pop,
  output logic                       out_strobe,
  output logic [rhsv_pkg::CH_W-1:0]  out_hue,
  output logic [rhsv_pkg::CH_W-1:0]  out_saturation,
  output logic [rhsv_pkg::CH_W-1:0]  out_brightness,
  output logic [rhsv_pkg::CH_W-1:0]  out_alpha_out
);
  import rhsv_pkg::*;

  typedef struct packed {
    logic [NUM_W-1:0] sat_rem;
    logic [NUM_W-1:0] hue_rem;
    logic [QUO_W-1:0] sat_q;
    logic [QUO_W-1:0] hue_q;
    logic [CH_W-1:0]  hi;
    logic [CH_W-1:0]  delta;
    logic [CH_W-1:0]  base;
    logic             neg;
    logic             sat_zero;
    logic             hue_zero;
    logic [CH_W-1:0]  alpha;
  } stage_t;

  stage_t                stg_in  [DIV_STAGES];
  stage_t                stg_nxt [DIV_STAGES];
  stage_t                stg_r   [DIV_STAGES];
  logic [DIV_STAGES-1:0] vld_r;
  logic [NUM_W-1:0]      sat_sh  [DIV_STAGES];
  logic [NUM_W-1:0]      hue_sh  [DIV_STAGES];
  logic [CH_W-1:0]       hue_val;
  stage_t                last;

  // Drain the queue every cycle; the pipeline never stalls
  assign pop = !q_stat.empty;

  // Feed each stage from the one before it
  always_comb begin
    stg_in[0]          = '0;
    stg_in[0].sat_rem  = head.sat_num;
    stg_in[0].hue_rem  = head.hue_num;
    stg_in[0].hi       = head.hi;
    stg_in[0].delta    = head.delta;
    stg_in[0].base     = head.base;
    stg_in[0].neg      = head.neg;
    stg_in[0].sat_zero = head.sat_zero;
    stg_in[0].hue_zero = head.hue_zero;
    stg_in[0].alpha    = head.alpha;
    for (int k = 1; k < DIV_STAGES; k++) begin
      stg_in[k] = stg_r[k-1];
    end
  end

  // One quotient bit per stage, most significant first
  always_comb begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      stg_nxt[k] = stg_in[k];
      sat_sh[k]  = NUM_W'(stg_in[k].hi) << (QUO_W - 1 - k);
      hue_sh[k]  = NUM_W'(stg_in[k].delta) << (QUO_W - 1 - k);
      if (stg_in[k].sat_rem >= sat_sh[k]) begin
        stg_nxt[k].sat_rem           = stg_in[k].sat_rem - sat_sh[k];
        stg_nxt[k].sat_q[QUO_W-1-k] = 1'b1;
      end
      if (stg_in[k].hue_rem >= hue_sh[k]) begin
        stg_nxt[k].hue_rem           = stg_in[k].hue_rem - hue_sh[k];
        stg_nxt[k].hue_q[QUO_W-1-k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[DIV_STAGES-2:0], pop};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      stg_r[k] <= stg_nxt[k];
    end
  end

  // Apply the sign and sector offset; hue wraps modulo 256
  assign last = stg_r[DIV_STAGES-1];
  always_comb begin
    if (last.hue_zero) begin
      hue_val = '0;
    end else if (last.neg) begin
      hue_val = last.base - CH_W'(last.hue_q);
    end else begin
      hue_val = last.base + CH_W'(last.hue_q);
    end
  end

  // Hold the result for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= vld_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    out_hue        <= hue_val;
    out_saturation <= last.sat_zero ? '0 : CH_W'(last.sat_q);
    out_brightness <= last.hi;
    out_alpha_out  <= last.alpha;
  end

endmodule

[test/tb.sv]
// Testbench for the 8-bit RGBA to HSVA conversion unit: directed table plus random pixels.
`timescale 1ns / 1ps

module tb;

  localparam int CW            = rhsv_pkg::CH_W;
  localparam int RANDOM_PIXELS = 1630;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [CW-1:0] red;
    logic [CW-1:0] green;
    logic [CW-1:0] blue;
    logic [CW-1:0] alpha;
  } rgba_t;

  typedef struct packed {
    logic [CW-1:0] hue;
    logic [CW-1:0] saturation;
    logic [CW-1:0] brightness;
    logic [CW-1:0] alpha;
  } hsva_t;

  // One directed row; typed_hsv is used only when typed is set.
  typedef struct packed {
    rgba_t px;
    logic  typed;
    hsva_t typed_hsv;
  } pixel_case_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  logic [CW-1:0] in_red = '0;
  logic [CW-1:0] in_green = '0;
  logic [CW-1:0] in_blue = '0;
  logic [CW-1:0] in_alpha_in = '0;
  logic          out_strobe;
  logic [CW-1:0] out_hue;
  logic [CW-1:0] out_saturation;
  logic [CW-1:0] out_brightness;
  logic [CW-1:0] out_alpha_out;

  hsva_t pending_hsv[$];
  hsva_t oldest_hsv;
  int    mismatch_count = 0;

  //                   R        G        B        A      typed  H        S        V        A
  pixel_case_t directed_cases [0:21] = '{
    {8'd0,   8'd0,   8'd0,   8'h00, 1'b1, 8'd0,   8'd0,   8'd0,   8'h00}, // black
    {8'd255, 8'd255, 8'd255, 8'hFF, 1'b1, 8'd0,   8'd0,   8'd255, 8'hFF}, // white
    {8'd128, 8'd128, 8'd128, 8'hA5, 1'b1, 8'd0,   8'd0,   8'd128, 8'hA5}, // mid grey
    {8'd255, 8'd0,   8'd0,   8'h00, 1'b1, 8'd0,   8'd255, 8'd255, 8'h00}, // pure red
    {8'd0,   8'd255, 8'd0,   8'hFF, 1'b1, 8'd85,  8'd255, 8'd255, 8'hFF}, // pure green
    {8'd0,   8'd0,   8'd255, 8'h5A, 1'b1, 8'd171, 8'd255, 8'd255, 8'h5A}, // pure blue
    {8'd255, 8'd0,   8'd10,  8'h33, 1'b1, 8'd255, 8'd255, 8'd255, 8'h33}, // hue wraps below 0
    {8'd255, 8'd255, 8'd0,   8'h11, 1'b1, 8'd43,  8'd255, 8'd255, 8'h11}, // red beats green
    {8'd0,   8'd255, 8'd255, 8'h22, 1'b1, 8'd128, 8'd255, 8'd255, 8'h22}, // green beats blue
    {8'd1,   8'd0,   8'd0,   8'h80, 1'b1, 8'd0,   8'd255, 8'd1,   8'h80}, // smallest red
    {8'd1,   8'd1,   8'd1,   8'h01, 1'b1, 8'd0,   8'd0,   8'd1,   8'h01}, // darkest grey
    {8'd255, 8'd0,   8'd255, 8'h44, 1'b0, 32'h0},                         // red beats blue
    {8'd0,   8'd0,   8'd1,   8'h7F, 1'b0, 32'h0},
    {8'd254, 8'd255, 8'd255, 8'hFE, 1'b0, 32'h0},
    {8'd0,   8'd10,  8'd255, 8'hC3, 1'b0, 32'h0},                         // blue, negative term
    {8'd10,  8'd255, 8'd0,   8'h3C, 1'b0, 32'h0},                         // green, negative term
    {8'h55,  8'hAA,  8'h55,  8'hAA, 1'b0, 32'h0},
    {8'hAA,  8'h55,  8'hAA,  8'h55, 1'b0, 32'h0},
    {8'd200, 8'd100, 8'd50,  8'h90, 1'b0, 32'h0},
    {8'd100, 8'd200, 8'd150, 8'h10, 1'b0, 32'h0},
    {8'd1,   8'd2,   8'd3,   8'hFE, 1'b0, 32'h0},
    {8'd254, 8'd253, 8'd1,   8'h01, 1'b0, 32'h0}
  };

  rgb_to_hsv_8bit_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_alpha_in    (in_alpha_in),
    .out_strobe     (out_strobe),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_brightness (out_brightness),
    .out_alpha_out  (out_alpha_out)
  );

  always #4 clk = ~clk;

  // Compute the HSVA form of one pixel.
  function automatic hsva_t rgb_to_hsv(input rgba_t px);
    int    peak;
    int    lowest;
    int    delta;
    int    sector;
    int    diff;
    int    angle;
    int    sat;
    hsva_t res;
    peak   = (px.red > px.green) ? px.red : px.green;
    peak   = (px.blue > peak) ? px.blue : peak;
    lowest = (px.red < px.green) ? px.red : px.green;
    lowest = (px.blue < lowest) ? px.blue : lowest;
    delta  = peak - lowest;
    sat    = (peak != 0) ? (255 * delta) / peak : 0;
    angle  = 0;
    // Pick the sector from the largest channel, red first, then green.
    if (delta != 0) begin
      if (peak == px.red) begin
        sector = int'(rhsv_pkg::HUE_BASE_RED);
        diff   = int'(px.green) - int'(px.blue);
      end else if (peak == px.green) begin
        sector = int'(rhsv_pkg::HUE_BASE_GREEN);
        diff   = int'(px.blue) - int'(px.red);
      end else begin
        sector = int'(rhsv_pkg::HUE_BASE_BLUE);
        diff   = int'(px.red) - int'(px.green);
      end
      angle = sector + (int'(rhsv_pkg::HUE_SCALE) * diff) / delta;
    end
    res.hue        = angle[CW-1:0];
    res.saturation = sat[CW-1:0];
    res.brightness = peak[CW-1:0];
    res.alpha      = px.alpha;
    return res;
  endfunction

  // Draw a pixel, biased toward greys, ties, near-greys and extremes.
  function automatic rgba_t random_pixel();
    rgba_t px;
    int    level;
    px = $urandom;
    case ($urandom_range(0, 9))
      5: begin
        px.green = px.red;
        px.blue  = px.red;
      end
      6: begin
        case ($urandom_range(0, 2))
          0: px.green = px.red;
          1: px.blue  = px.red;
          default: px.blue = px.green;
        endcase
      end
      7: begin
        level    = $urandom_range(3, 255);
        px.red   = CW'(level - $urandom_range(0, 3));
        px.green = CW'(level - $urandom_range(0, 3));
        px.blue  = CW'(level - $urandom_range(0, 3));
      end
      8: begin
        px.red   = CW'($urandom_range(0, 3));
        px.green = CW'($urandom_range(0, 3));
        px.blue  = CW'($urandom_range(0, 3));
      end
      9: begin
        px.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        px.blue  = $urandom_range(0, 1) ? 8'hFF : px.blue;
      end
      default: ;
    endcase
    return px;
  endfunction

  // Mostly short gaps, a few long ones; none while bursting.
  function automatic int pick_gap(input bit burst);
    int roll;
    roll = $urandom_range(0, 99);
    if (burst || roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one pixel and hold it until the transaction is taken.
  task automatic send_pixel(input rgba_t px, input bit typed, input hsva_t typed_hsv);
    in_red      <= px.red;
    in_green    <= px.green;
    in_blue     <= px.blue;
    in_alpha_in <= px.alpha;
    start       <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    pending_hsv.push_back(typed ? typed_hsv : rgb_to_hsv(px));
  endtask

  // Drop start for a number of cycles, with noise on the pixel inputs.
  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) begin
      in_red      <= CW'($urandom);
      in_green    <= CW'($urandom);
      in_blue     <= CW'($urandom);
      in_alpha_in <= CW'($urandom);
      @(posedge clk);
    end
  endtask

  task automatic check_field(input string name, input logic [CW-1:0] want,
                             input logic [CW-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Compare each strobed result with the oldest expected one.
  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_hsv.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with none expected, hue %0d sat %0d val %0d alpha %0d",
                 $time, out_hue, out_saturation, out_brightness, out_alpha_out);
      end else begin
        oldest_hsv = pending_hsv.pop_front();
        check_field("hue", oldest_hsv.hue, out_hue);
        check_field("saturation", oldest_hsv.saturation, out_saturation);
        check_field("brightness", oldest_hsv.brightness, out_brightness);
        check_field("alpha", oldest_hsv.alpha, out_alpha_out);
      end
    end
  end

  initial begin
    int gap;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table.
    foreach (directed_cases[i]) begin
      send_pixel(directed_cases[i].px, directed_cases[i].typed, directed_cases[i].typed_hsv);
      gap = pick_gap(1'b0);
      if (gap > 0) hold_off(gap);
    end

    // Random pixels, with back-to-back bursts in every third block.
    for (int n = 0; n < RANDOM_PIXELS; n++) begin
      send_pixel(random_pixel(), 1'b0, '0);
      if (n == RANDOM_PIXELS / 2) begin
        // Hold the source until the pipeline has emptied.
        start <= 1'b0;
        while (pending_hsv.size() != 0) @(posedge clk);
      end else begin
        gap = pick_gap((n / 128) % 3 == 1);
        if (gap > 0) hold_off(gap);
      end
    end

    start <= 1'b0;
    while (pending_hsv.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // End a hung run.
  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/rhsv_pkg.sv
rtl/core/rhsv_front.sv
rtl/core/rhsv_queue.sv
rtl/core/rhsv_back.sv
rtl/core/rgb_to_hsv_8bit_unit.sv
test/tb.sv
